// ===== src/case_insensitive_substring_match_assert.svh =====
// assertion macros used by the substring match rtl
// no dependencies; included by the top level, the only file that carries assertions
`ifndef CASE_INSENSITIVE_SUBSTRING_MATCH_ASSERT_SVH
`define CASE_INSENSITIVE_SUBSTRING_MATCH_ASSERT_SVH

// property holds at every edge outside reset
`define CISM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define CISM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/cism_pkg.sv =====
// shared types and constants for the case-insensitive substring match
// no dependencies
package cism_pkg;

	localparam int NEEDLE_MAX_DEF = 32;
	localparam int CHAR_WIDTH_DEF = 16;

	localparam int REQ_WIDTH  = 2;
	localparam int CODE_WIDTH = 16;

	localparam logic [7:0] UPPER_A     = 8'h41;
	localparam logic [7:0] UPPER_Z     = 8'h5A;
	localparam logic [7:0] LOWER_A     = 8'h61;
	localparam logic [7:0] CASE_OFFSET = LOWER_A - UPPER_A;

	typedef enum logic [REQ_WIDTH-1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_SCAN   = 2'd2,
		REQ_FINISH = 2'd3
	} req_t;

	typedef struct packed {
		logic clr_match;
		logic wr;
		logic scan;
	} cism_ctrl_t;

	typedef struct packed {
		logic found;
		logic needle_overflow;
	} cism_res_t;

endpackage

// ===== src/cism_if.sv =====
// valid/ready stream interfaces for request and result channels
// depends on cism_pkg for field widths
interface cism_req_if;
	logic                            valid;
	logic                            ready;
	logic [cism_pkg::REQ_WIDTH-1:0]  req_type;
	logic [cism_pkg::CODE_WIDTH-1:0] char_code;

	modport source (output valid, output req_type, output char_code, input ready);
	modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

interface cism_res_if;
	logic valid;
	logic ready;
	logic found;
	logic needle_overflow;

	modport source (output valid, output found, output needle_overflow, input ready);
	modport sink   (input valid, input found, input needle_overflow, output ready);
endinterface

// ===== src/case_insensitive_substring_match.sv =====
// top level of the case-insensitive substring match: request decode, cell chain, result buffer
// depends on cism_pkg, cism_if, cism_cell, cism_out_buf and the assertion header
//
// Streams one request per clock cycle while ready is high: clear, append a needle character,
// scan a haystack character, or finish. Every needle position is a cell that compares its
// stored character with the broadcast haystack character and passes its partial-match bit to
// the next cell, so a scan completes in the cycle it is accepted. A finish transaction yields
// one result, registered in the output register or the skid slot; a two-entry result buffer
// keeps requests flowing while a result waits, and ready drops only when both entries are
// full. Only ASCII A to Z are folded to lower case. An empty needle reports found; appending
// past NeedleMax characters sets needle_overflow and forces found low until the next clear.
`include "case_insensitive_substring_match_assert.svh"

module case_insensitive_substring_match #(
	parameter int NeedleMax = cism_pkg::NEEDLE_MAX_DEF,
	parameter int CharWidth = cism_pkg::CHAR_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	cism_req_if.sink   req,
	cism_res_if.source res
);

	localparam int LenWidth = $clog2(NeedleMax + 1);

	logic                 accept;
	cism_pkg::req_t       req_kind;
	logic [CharWidth-1:0] ch_raw;
	logic [CharWidth-1:0] ch_fold;
	logic [LenWidth-1:0]  len_q;
	logic                 found_q;
	logic                 ovf_q;
	logic                 full;
	cism_pkg::cism_ctrl_t ctrl;
	logic                 push;
	logic                 push_ready;
	cism_pkg::cism_res_t  push_data;
	cism_pkg::cism_res_t  out_data;
	logic [NeedleMax-1:0] match_vec;
	logic [NeedleMax-1:0] hit_vec;

	assign req.ready = push_ready;
	assign accept    = req.valid && push_ready;
	assign req_kind  = cism_pkg::req_t'(req.req_type);
	assign full      = (len_q == LenWidth'(NeedleMax));

	assign ch_raw  = CharWidth'(req.char_code);
	assign ch_fold = ((ch_raw >= CharWidth'(cism_pkg::UPPER_A)) &&
	                  (ch_raw <= CharWidth'(cism_pkg::UPPER_Z))) ?
	                 ch_raw + CharWidth'(cism_pkg::CASE_OFFSET) : ch_raw;

	always_comb begin
		ctrl = '0;
		push = 1'b0;
		if (accept) begin
			unique case (req_kind)
				cism_pkg::REQ_CLEAR: begin
					ctrl.clr_match = 1'b1;
				end
				cism_pkg::REQ_APPEND: begin
					ctrl.clr_match = 1'b1;
					ctrl.wr        = !full;
				end
				cism_pkg::REQ_SCAN: begin
					ctrl.scan = 1'b1;
				end
				cism_pkg::REQ_FINISH: begin
					push = 1'b1;
				end
				default: begin
					ctrl = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			found_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			unique case (req_kind)
				cism_pkg::REQ_CLEAR: begin
					len_q   <= '0;
					found_q <= 1'b0;
					ovf_q   <= 1'b0;
				end
				cism_pkg::REQ_APPEND: begin
					found_q <= 1'b0;
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						len_q <= len_q + LenWidth'(1);
					end
				end
				cism_pkg::REQ_SCAN: begin
					if (|hit_vec) begin
						found_q <= 1'b1;
					end
				end
				cism_pkg::REQ_FINISH: begin
					found_q <= found_q;
				end
				default: begin
					found_q <= found_q;
				end
			endcase
		end
	end

	for (genvar i = 0; i < NeedleMax; i++) begin : g_cell
		logic match_in;
		if (i == 0) begin : g_head
			assign match_in = 1'b1;
		end else begin : g_link
			assign match_in = match_vec[i-1];
		end

		cism_cell #(
			.CharWidth (CharWidth),
			.LenWidth  (LenWidth),
			.Index     (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.ch        (ch_fold),
			.len       (len_q),
			.match_in  (match_in),
			.match_out (match_vec[i]),
			.hit       (hit_vec[i])
		);
	end

	// result reflects the state before the finish transaction
	assign push_data.found           = !ovf_q && ((len_q == '0) || found_q);
	assign push_data.needle_overflow = ovf_q;

	cism_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.out_valid  (res.valid),
		.out_ready  (res.ready),
		.out_data   (out_data)
	);

	assign res.found           = out_data.found;
	assign res.needle_overflow = out_data.needle_overflow;

	`CISM_ASSERT(a_ovf_full, clk, arst_n, !ovf_q || full, "overflow set with needle not full")
	`CISM_ASSERT(a_found_len, clk, arst_n, !found_q || (len_q != '0), "found set with empty needle")
	`CISM_ASSERT(a_hit_scan, clk, arst_n, (hit_vec == '0) || ctrl.scan, "hit outside a scan")
	`CISM_ASSERT_NEXT(a_append_len, clk, arst_n,
		accept && (req_kind == cism_pkg::REQ_APPEND) && !full,
		len_q == $past(len_q) + LenWidth'(1), "append did not grow the needle")

endmodule

// ===== src/cism_cell.sv =====
// one needle position: stored folded character and its partial-match bit
// depends on cism_pkg for the control struct
module cism_cell #(
	parameter int CharWidth = cism_pkg::CHAR_WIDTH_DEF,
	parameter int LenWidth  = $clog2(cism_pkg::NEEDLE_MAX_DEF + 1),
	parameter int Index     = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cism_pkg::cism_ctrl_t   ctrl,
	input  logic [CharWidth-1:0]   ch,
	input  logic [LenWidth-1:0]    len,
	input  logic                   match_in,
	output logic                   match_out,
	output logic                   hit
);

	logic [CharWidth-1:0] char_q;
	logic                 match_q;
	logic                 match_next;

	// written only at the tail slot, never reset
	always_ff @(posedge clk) begin
		if (ctrl.wr && (len == LenWidth'(Index))) begin
			char_q <= ch;
		end
	end

	assign match_next = match_in && (char_q == ch);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.clr_match) begin
			match_q <= 1'b0;
		end else if (ctrl.scan) begin
			match_q <= match_next;
		end
	end

	assign match_out = match_q;
	// only the last needle position can set found
	assign hit       = ctrl.scan && match_next && (len == LenWidth'(Index + 1));

endmodule

// ===== src/cism_out_buf.sv =====
// two-entry result buffer: output register plus skid slot
// depends on cism_pkg for the result struct
module cism_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cism_pkg::cism_res_t push_data,
	output logic                push_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output cism_pkg::cism_res_t out_data
);

	logic                out_valid_q;
	logic                skid_valid_q;
	cism_pkg::cism_res_t out_data_q;
	cism_pkg::cism_res_t skid_data_q;
	logic                out_fire;

	assign out_fire   = out_valid_q && out_ready;
	assign push_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (!out_valid_q || out_fire) begin
				out_data_q <= push_data;
			end else begin
				skid_data_q <= push_data;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== test/substring_match_checker.sv =====
// scoreboard for the case-insensitive substring match: watches both channels,
// predicts each report from the request stream and compares field by field
// depends on cism_pkg and the channel interfaces in cism_if
module substring_match_checker (
	input  logic        clk,
	input  logic        arst_n,
	cism_req_if         req_mon,
	cism_res_if         res_mon,
	output int unsigned expected_count,
	output int unsigned mismatch_count,
	output int unsigned reports_seen,
	output int unsigned reports_found
);
	import cism_pkg::*;

	logic [CODE_WIDTH-1:0]     needle_chars [NEEDLE_MAX_DEF];
	int unsigned               needle_len;
	logic [NEEDLE_MAX_DEF-1:0] prefix_hits;
	logic                      hit_seen;
	logic                      too_long;
	cism_res_t                 pending_reports [$];
	int unsigned               errors;
	int unsigned               checked;
	int unsigned               hits;

	task automatic track_request(input req_t kind, input logic [CODE_WIDTH-1:0] code);
		logic [CODE_WIDTH-1:0] ch;
		cism_res_t             report;
		// only A to Z fold; anything with high bits set stays as it is
		ch = code;
		if (code >= CODE_WIDTH'(UPPER_A) && code <= CODE_WIDTH'(UPPER_Z))
			ch = code + CODE_WIDTH'(CASE_OFFSET);
		case (kind)
			REQ_CLEAR: begin
				needle_len  = 0;
				prefix_hits = '0;
				hit_seen    = 1'b0;
				too_long    = 1'b0;
			end
			REQ_APPEND: begin
				if (needle_len < NEEDLE_MAX_DEF) begin
					needle_chars[needle_len] = ch;
					needle_len++;
				end else begin
					too_long = 1'b1;
				end
				// earlier haystack is forgotten on every append, also one that overflows
				prefix_hits = '0;
				hit_seen    = 1'b0;
			end
			REQ_SCAN: begin
				if (needle_len != 0) begin
					for (int i = int'(needle_len) - 1; i > 0; i--)
						prefix_hits[i] = prefix_hits[i-1] && (needle_chars[i] == ch);
					prefix_hits[0] = (needle_chars[0] == ch);
					if (prefix_hits[needle_len-1])
						hit_seen = 1'b1;
				end
			end
			default: begin
				report.found           = !too_long && (needle_len == 0 || hit_seen);
				report.needle_overflow = too_long;
				pending_reports.push_back(report);
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		cism_res_t want;
		if (!arst_n) begin
			needle_len  = 0;
			prefix_hits = '0;
			hit_seen    = 1'b0;
			too_long    = 1'b0;
			errors      = 0;
			checked     = 0;
			hits        = 0;
			pending_reports.delete();
			expected_count <= 0;
			mismatch_count <= 0;
			reports_seen   <= 0;
			reports_found  <= 0;
		end else begin
			// the report leaving now belongs to an earlier finish, so pop before pushing
			if (res_mon.valid && res_mon.ready) begin
				if (pending_reports.size() == 0) begin
					$display("%0t: unexpected report, found %0b overflow %0b", $time,
						res_mon.found, res_mon.needle_overflow);
					errors++;
				end else begin
					want = pending_reports.pop_front();
					if (res_mon.found !== want.found) begin
						$display("%0t: found mismatch, expected %0b, actual %0b", $time,
							want.found, res_mon.found);
						errors++;
					end
					if (res_mon.needle_overflow !== want.needle_overflow) begin
						$display("%0t: needle_overflow mismatch, expected %0b, actual %0b",
							$time, want.needle_overflow, res_mon.needle_overflow);
						errors++;
					end
					checked++;
					if (want.found)
						hits++;
				end
			end
			if (req_mon.valid && req_mon.ready)
				track_request(req_t'(req_mon.req_type), req_mon.char_code);
			expected_count <= pending_reports.size();
			mismatch_count <= errors;
			reports_seen   <= checked;
			reports_found  <= hits;
		end
	end

endmodule

// ===== test/testbench.sv =====
// top of the substring match testbench: clock, reset, request stimulus,
// report back-pressure, watchdog and verdict
// depends on cism_pkg, cism_if, the block itself and substring_match_checker
module testbench;
	import cism_pkg::*;

	localparam int ITEMS          = 1650;
	localparam int IDLE_PCT       = 8;
	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 8;

	logic        clk;
	logic        arst_n;
	logic        quiet;
	int unsigned hold_reqs;
	int unsigned n_sent;
	int unsigned n_searches;
	int unsigned n_overlong;
	int unsigned expected_count;
	int unsigned mismatch_count;
	int unsigned reports_seen;
	int unsigned reports_found;

	cism_req_if req_ch ();
	cism_res_if res_ch ();

	case_insensitive_substring_match u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	substring_match_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_mon        (req_ch),
		.res_mon        (res_ch),
		.expected_count (expected_count),
		.mismatch_count (mismatch_count),
		.reports_seen   (reports_seen),
		.reports_found  (reports_found)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// one transaction on the request channel, with random gaps in front
	task automatic offer(input req_t kind, input logic [CODE_WIDTH-1:0] code);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= kind;
		req_ch.char_code <= code;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		n_sent++;
	endtask

	function automatic logic [CODE_WIDTH-1:0] mix_case(input logic [CODE_WIDTH-1:0] c);
		logic [CODE_WIDTH-1:0] low;
		low = c | CODE_WIDTH'(CASE_OFFSET);
		if (low >= CODE_WIDTH'(LOWER_A) && low <= CODE_WIDTH'(LOWER_A) + 16'd25)
			return $urandom_range(1) ? low : (c & ~CODE_WIDTH'(CASE_OFFSET));
		return c;
	endfunction

	// clear, build a needle from a small alphabet, then stream haystack that
	// now and then carries the needle or a prefix of it, mixed with finishes and appends
	task automatic run_search(input bit overlong);
		logic [CODE_WIDTH-1:0] alpha [4];
		logic [CODE_WIDTH-1:0] pat [$];
		logic [CODE_WIDTH-1:0] c;
		int                    nlen;
		int                    hlen;
		int                    r;
		int                    cut;
		for (int k = 0; k < 4; k++) begin
			case ($urandom_range(5))
				0, 1, 2: alpha[k] = 16'h0061 + 16'($urandom_range(25));
				3:       alpha[k] = 16'($urandom);
				4: begin
					case ($urandom_range(5))
						0:       alpha[k] = 16'h0040;
						1:       alpha[k] = 16'h005B;
						2:       alpha[k] = 16'h0060;
						3:       alpha[k] = 16'h007B;
						4:       alpha[k] = 16'hFFFF;
						default: alpha[k] = 16'h0000;
					endcase
				end
				default: alpha[k] = 16'h0041 + 16'($urandom_range(25))
					+ (16'($urandom_range(1, 255)) << 8);
			endcase
		end
		r = $urandom_range(99);
		if (overlong)
			nlen = $urandom_range(NEEDLE_MAX_DEF + 1, NEEDLE_MAX_DEF + 4);
		else if (r < 5)
			nlen = 0;
		else if (r < 85)
			nlen = $urandom_range(1, 4);
		else if (r < 95)
			nlen = $urandom_range(5, NEEDLE_MAX_DEF);
		else
			nlen = $urandom_range(NEEDLE_MAX_DEF - 1, NEEDLE_MAX_DEF + 3);
		if (nlen > NEEDLE_MAX_DEF)
			n_overlong++;
		n_searches++;
		offer(REQ_CLEAR, 16'($urandom));
		for (int i = 0; i < nlen; i++) begin
			c = alpha[$urandom_range(3)];
			pat.push_back(c);
			offer(REQ_APPEND, mix_case(c));
		end
		hlen = $urandom_range(0, 20) + ((nlen > 4) ? nlen : 0);
		for (int h = 0; h < hlen; h++) begin
			r = $urandom_range(99);
			if (r < 15 && pat.size() != 0) begin
				foreach (pat[j])
					offer(REQ_SCAN, mix_case(pat[j]));
			end else if (r < 20 && pat.size() > 1) begin
				cut = $urandom_range(1, pat.size() - 1);
				for (int j = 0; j < cut; j++)
					offer(REQ_SCAN, mix_case(pat[j]));
			end else if (r < 27) begin
				offer(REQ_FINISH, 16'($urandom));
			end else if (r < 31) begin
				c = alpha[$urandom_range(3)];
				pat.push_back(c);
				offer(REQ_APPEND, mix_case(c));
			end else begin
				offer(REQ_SCAN, mix_case(alpha[$urandom_range(3)]));
			end
		end
		offer(REQ_FINISH, 16'($urandom));
		if ($urandom_range(3) == 0)
			offer(REQ_FINISH, 16'($urandom));
	endtask

	// report side: random stalls, plus a long hold-off whenever one is requested
	initial begin
		int unsigned hold_seen;
		int          hold_left;
		hold_seen = 0;
		hold_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
				res_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// ends the run when no transaction moves on either channel for too long
	initial begin
		int stall;
		stall = 0;
		while (stall < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (arst_n && !(req_ch.valid && req_ch.ready) && !(res_ch.valid && res_ch.ready))
				stall++;
			else
				stall = 0;
		end
		$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("case_insensitive_substring_match test failed");
		$finish;
	end

	initial begin
		bit held;
		bit paused;
		bit quiet_done;
		int search_idx;
		held       = 1'b0;
		paused     = 1'b0;
		quiet_done = 1'b0;
		search_idx = 0;
		n_sent     = 0;
		n_searches = 0;
		n_overlong = 0;
		hold_reqs        <= 0;
		quiet            <= 1'b0;
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.req_type  <= REQ_CLEAR;
		req_ch.char_code <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty needle straight after reset, and a scan that cannot change it
		offer(REQ_FINISH, 16'hFFFF);
		offer(REQ_SCAN, 16'h0061);
		offer(REQ_FINISH, 16'h0000);
		// mixed-case needle found through folded haystack, finish repeated
		offer(REQ_CLEAR, 16'hFFFF);
		offer(REQ_APPEND, 16'h0041);
		offer(REQ_APPEND, 16'h007A);
		offer(REQ_SCAN, 16'h005B);
		offer(REQ_SCAN, 16'h0061);
		offer(REQ_SCAN, 16'h005A);
		offer(REQ_FINISH, 16'h0000);
		offer(REQ_FINISH, 16'h1234);
		// append after haystack drops the earlier match
		offer(REQ_APPEND, 16'h0040);
		offer(REQ_FINISH, 16'h0000);
		// '@' and '`' sit just outside the folded range
		offer(REQ_SCAN, 16'h0061);
		offer(REQ_SCAN, 16'h007A);
		offer(REQ_SCAN, 16'h0060);
		offer(REQ_SCAN, 16'h0041);
		offer(REQ_SCAN, 16'h005A);
		offer(REQ_SCAN, 16'h0040);
		offer(REQ_FINISH, 16'h0000);
		// extreme codes and '[' against '{'
		offer(REQ_CLEAR, 16'h0000);
		offer(REQ_APPEND, 16'hFFFF);
		offer(REQ_APPEND, 16'h0000);
		offer(REQ_APPEND, 16'h007B);
		offer(REQ_SCAN, 16'hFFFF);
		offer(REQ_SCAN, 16'h0000);
		offer(REQ_SCAN, 16'h005B);
		offer(REQ_FINISH, 16'hFFFF);

		while (n_sent < ITEMS) begin
			if ($urandom_range(9) < 8) begin
				run_search(search_idx % 12 == 0);
				search_idx++;
			end else begin
				repeat ($urandom_range(1, 8))
					offer(req_t'($urandom_range(3)), 16'($urandom));
			end
			if (!held && n_sent >= 500) begin
				// reports back up while finishes keep coming, so requests stall
				held = 1'b1;
				hold_reqs <= hold_reqs + 1;
				repeat (12)
					offer(REQ_FINISH, 16'($urandom));
			end
			if (!paused && n_sent >= 900) begin
				paused = 1'b1;
				req_ch.valid <= 1'b0;
				@(posedge clk);
				while (expected_count != 0)
					@(posedge clk);
			end
			if (!quiet_done && n_sent >= 1100) begin
				quiet_done = 1'b1;
				quiet <= 1'b1;
			end
			if (quiet && n_sent >= 1400)
				quiet <= 1'b0;
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests over %0d searches, %0d of them with over-long needles",
			n_sent, n_searches, n_overlong);
		$display("checked %0d reports, %0d with the needle found", reports_seen, reports_found);
		if (mismatch_count == 0 && expected_count == 0)
			$display("case_insensitive_substring_match test passed");
		else
			$display("case_insensitive_substring_match test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/cism_pkg.sv
src/cism_if.sv
src/cism_cell.sv
src/cism_out_buf.sv
src/case_insensitive_substring_match.sv
test/substring_match_checker.sv
test/testbench.sv
